FILE: hw/rtl/assert_macros.svh
// Assertion helpers shared by the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every rising clock edge outside reset.
`define CDS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define CDS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: hw/rtl/cds_pkg.sv
`default_nettype none
package cds_pkg;

  // Batch store geometry
  localparam int MAX_REQ = 32;
  localparam int TRACK_W = 16;
  localparam int IDX_W   = $clog2(MAX_REQ);
  localparam int CNT_W   = IDX_W + 1;
  localparam int MOVE_W  = TRACK_W + 1;

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_DISK_SIZE = 1'b0;
  localparam logic REG_HEAD_POS  = 1'b1;
  localparam logic [TRACK_W-1:0] DISK_SIZE_RST = '1;

  typedef struct packed {
    logic [TRACK_W-1:0] track;
    logic               last;
  } cds_in_t;

  typedef struct packed {
    logic [TRACK_W-1:0] granted_track;
    logic [MOVE_W-1:0]  total_movement;
    logic               final_res;
  } cds_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic scan;
    logic decide;
    logic move;
    logic emit;
  } cds_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_done;
    logic emit_last;
  } cds_sts_t;

endpackage
`default_nettype wire

FILE: hw/rtl/cds_ctrl.sv
`default_nettype none
`include "assert_macros.svh"
module cds_ctrl
  import cds_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  input  wire logic     in_last,
  input  wire cds_sts_t sts,
  output logic          busy,
  output cds_cmd_t      cmd
);

  localparam logic [2:0] ST_LOAD = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_DIR  = 3'd2;
  localparam logic [2:0] ST_MOVE = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign busy = (state_r != ST_LOAD);

  // Decode commands from the state
  always_comb begin
    cmd        = '0;
    cmd.load   = (state_r == ST_LOAD) && start;
    cmd.scan   = (state_r == ST_SCAN);
    cmd.decide = (state_r == ST_DIR);
    cmd.move   = (state_r == ST_MOVE);
    cmd.emit   = (state_r == ST_EMIT);
  end

  // Advance through load, scan, decide, move and emit
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: if (start && in_last) state_nxt = ST_SCAN;
      ST_SCAN: if (sts.scan_done) state_nxt = ST_DIR;
      ST_DIR:  state_nxt = ST_MOVE;
      ST_MOVE: state_nxt = ST_EMIT;
      ST_EMIT: if (sts.emit_last) state_nxt = ST_LOAD;
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  `CDS_ASSERT(a_emit_ends, clk, rst_n, (state_r == ST_EMIT && sts.emit_last) |=> (state_r == ST_LOAD), "emit did not return to load")
  `CDS_ASSERT(a_last_busy, clk, rst_n, (state_r == ST_LOAD && start && in_last) |=> busy, "last item did not start scheduling")

endmodule
`default_nettype wire

FILE: hw/rtl/cds_dp.sv
`default_nettype none
`include "assert_macros.svh"
module cds_dp
  import cds_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cds_cmd_t           cmd,
  input  wire logic [TRACK_W-1:0] in_track,
  input  wire logic [TRACK_W-1:0] size_eff,
  input  wire logic [TRACK_W-1:0] size_m1,
  input  wire logic [TRACK_W-1:0] head_eff,
  output cds_sts_t                sts,
  output logic                    out_valid,
  output cds_out_t                out_data
);

  // Sorted request store, ascending from entry 0
  logic [TRACK_W-1:0] req_r [MAX_REQ];
  logic [CNT_W-1:0]   count_r;
  logic [TRACK_W-1:0] max_r;
  logic [CNT_W-1:0]   idx_r;
  logic [CNT_W-1:0]   nb_r;
  logic [CNT_W-1:0]   rem_r;
  logic [TRACK_W-1:0] lo_r;
  logic [TRACK_W-1:0] hi_r;
  logic               down_r;
  logic [MOVE_W-1:0]  mv_r;
  logic               out_valid_r;
  cds_out_t           out_r;

  logic [TRACK_W-1:0] trk;
  logic               full;
  logic [MAX_REQ-1:0] le;
  logic [MAX_REQ-1:0] prev_le;
  logic [TRACK_W-1:0] prev_val [MAX_REQ];
  logic [TRACK_W-1:0] rd;
  logic               scan_hit;
  logic               has_lo;
  logic               has_hi;
  logic [TRACK_W-1:0] gap_lo;
  logic [TRACK_W-1:0] gap_hi;
  logic [MOVE_W-1:0]  mv_nxt;
  logic [CNT_W-1:0]   last_idx;

  // Clamp the incoming track and find its insertion point
  assign trk  = (in_track > size_m1) ? size_m1 : in_track;
  assign full = (count_r == CNT_W'(MAX_REQ));

  always_comb begin
    for (int i = 0; i < MAX_REQ; i++) begin
      le[i] = (CNT_W'(i) < count_r) && (req_r[i] <= trk);
    end
    prev_le     = {le[MAX_REQ-2:0], 1'b1};
    prev_val[0] = trk;
    for (int i = 1; i < MAX_REQ; i++) begin
      prev_val[i] = req_r[i-1];
    end
  end

  // Single indexed read port of the store
  assign rd       = req_r[idx_r[IDX_W-1:0]];
  assign scan_hit = (idx_r == count_r) || (rd > head_eff);
  assign last_idx = count_r - CNT_W'(1);

  // Side occupancy and neighbor distances
  assign has_lo = (nb_r != '0);
  assign has_hi = (nb_r != count_r);
  assign gap_lo = head_eff - lo_r;
  assign gap_hi = hi_r - head_eff;

  // Total travel for the chosen direction
  always_comb begin
    if (!has_lo) begin
      mv_nxt = MOVE_W'(max_r) - MOVE_W'(head_eff);
    end else if (down_r) begin
      mv_nxt = MOVE_W'(head_eff) + (has_hi ? (MOVE_W'(size_eff) - MOVE_W'(hi_r)) : '0);
    end else begin
      mv_nxt = MOVE_W'(size_eff) - MOVE_W'(head_eff) + MOVE_W'(lo_r);
    end
  end

  assign sts.scan_done = scan_hit;
  assign sts.emit_last = (rem_r == CNT_W'(1));

  // Insert each accepted request in sorted position
  always_ff @(posedge clk) begin
    if (cmd.load && !full) begin
      for (int i = 0; i < MAX_REQ; i++) begin
        if (!le[i]) begin
          req_r[i] <= prev_le[i] ? trk : prev_val[i];
        end
      end
      max_r <= (count_r == '0 || trk > max_r) ? trk : max_r;
    end
  end

  // Scan, decide, move and emit payload
  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      if (scan_hit) begin
        hi_r <= rd;
      end else begin
        lo_r <= rd;
      end
    end
    if (cmd.decide) begin
      down_r <= has_lo && (!has_hi || (gap_lo < gap_hi));
    end
    if (cmd.move) begin
      mv_r <= mv_nxt;
    end
    if (cmd.emit) begin
      out_r.granted_track  <= rd;
      out_r.total_movement <= mv_r;
      out_r.final_res      <= (rem_r == CNT_W'(1));
    end
  end

  // Count, walk index, neighbor split, remaining count and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      idx_r       <= '0;
      nb_r        <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
      if (cmd.load) begin
        idx_r <= '0;
        if (!full) begin
          count_r <= count_r + CNT_W'(1);
        end
      end
      if (cmd.scan) begin
        if (scan_hit) begin
          nb_r <= idx_r;
        end else begin
          idx_r <= idx_r + CNT_W'(1);
        end
      end
      if (cmd.move) begin
        idx_r <= down_r ? (nb_r - CNT_W'(1)) : nb_r;
        rem_r <= count_r;
      end
      if (cmd.emit) begin
        rem_r <= rem_r - CNT_W'(1);
        if (down_r) begin
          idx_r <= (idx_r == '0) ? last_idx : (idx_r - CNT_W'(1));
        end else begin
          idx_r <= (idx_r == last_idx) ? '0 : (idx_r + CNT_W'(1));
        end
        if (rem_r == CNT_W'(1)) begin
          count_r <= '0;
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `CDS_ASSERT_NEVER(a_count_range, clk, rst_n, count_r > CNT_W'(MAX_REQ), "request count over store depth")
  `CDS_ASSERT(a_valid_src, clk, rst_n, out_valid_r |-> $past(cmd.emit), "result without emit step")
  `CDS_ASSERT(a_final_clear, clk, rst_n, (out_valid_r && out_r.final_res) |-> (count_r == '0), "batch not cleared on final result")

endmodule
`default_nettype wire

FILE: hw/rtl/cscan_disk_scheduler.sv
`default_nettype none
// C-SCAN disk scheduler. Requests are loaded one per cycle while busy is low;
// the item with last set closes the batch (up to 32 requests kept, the rest
// dropped) and raises busy. The batch is then scheduled: a scan of the sorted
// store locates the head by stepping over each request at or below it, the
// decide and move steps pick the direction and total travel, then one result
// per cycle is strobed on out_valid, one per stored request. out_valid lasts
// exactly one cycle per result and cannot be stalled; the receiver must take
// every result as it appears. The sort costs nothing extra since each request is
// inserted in order as it arrives. Configuration writes take effect at once, so
// make them only while no batch is open or being scheduled.
module cscan_disk_scheduler
  import cds_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire cds_in_t            in_data,
  output logic                    out_valid,
  output cds_out_t                out_data,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0]      prdata,
  output logic                    pready
);

  logic [TRACK_W-1:0] disk_size_r;
  logic [TRACK_W-1:0] head_pos_r;
  logic [TRACK_W-1:0] size_eff;
  logic [TRACK_W-1:0] size_m1;
  logic [TRACK_W-1:0] head_eff;
  logic               reg_sel;
  logic               wr_en;
  cds_cmd_t           cmd;
  cds_sts_t           sts;

  // Register file writes
  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disk_size_r <= DISK_SIZE_RST;
      head_pos_r  <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        REG_DISK_SIZE: disk_size_r <= pwdata[TRACK_W-1:0];
        REG_HEAD_POS:  head_pos_r  <= pwdata[TRACK_W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (reg_sel)
      REG_DISK_SIZE: prdata = PDATA_W'(disk_size_r);
      REG_HEAD_POS:  prdata = PDATA_W'(head_pos_r);
      default:       prdata = '0;
    endcase
  end

  // Treat a zero disk size as one track and keep the head on the disk
  assign size_eff = (disk_size_r == '0) ? TRACK_W'(1) : disk_size_r;
  assign size_m1  = size_eff - TRACK_W'(1);
  assign head_eff = (head_pos_r > size_m1) ? size_m1 : head_pos_r;

  cds_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_last (in_data.last),
    .sts     (sts),
    .busy    (busy),
    .cmd     (cmd)
  );

  cds_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_track  (in_data.track),
    .size_eff  (size_eff),
    .size_m1   (size_m1),
    .head_eff  (head_eff),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
